[design/kced_pkg.sv]
// Package for the key click event detector: item types, flag bits,
// click machine codes, register indexes and reset values.
// No dependencies.
package kced_pkg;

    // Number of keys, one per bit of the key level field.
    localparam int NUM_KEYS = 4;

    localparam int LEVEL_W = 4;
    localparam int INDEX_W = 2;
    localparam int FLAG_W = 7;
    localparam int TIMER_W = 16;
    localparam int DIV_W = 8;
    localparam int CLICK_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Event flag bits.
    localparam logic [FLAG_W-1:0] FLG_HOLD   = 7'h01;
    localparam logic [FLAG_W-1:0] FLG_DOWN   = 7'h02;
    localparam logic [FLAG_W-1:0] FLG_UP     = 7'h04;
    localparam logic [FLAG_W-1:0] FLG_SINGLE = 7'h08;
    localparam logic [FLAG_W-1:0] FLG_DOUBLE = 7'h10;
    localparam logic [FLAG_W-1:0] FLG_LONG   = 7'h20;
    localparam logic [FLAG_W-1:0] FLG_REPEAT = 7'h40;

    // Click machine states.
    localparam logic [CLICK_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [CLICK_W-1:0] ST_PRESSED = 3'd1;
    localparam logic [CLICK_W-1:0] ST_WAIT    = 3'd2;
    localparam logic [CLICK_W-1:0] ST_SECOND  = 3'd3;
    localparam logic [CLICK_W-1:0] ST_REPEAT  = 3'd4;

    // Item functions.
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_DIV    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW  = 3'd4;

    // Register values after reset.
    localparam logic [DIV_W-1:0]   RST_SCAN_DIV   = 8'd20;
    localparam logic [TIMER_W-1:0] RST_LONG_TICKS = 16'd2000;
    localparam logic [TIMER_W-1:0] RST_DOUBLE_WIN = 16'd200;
    localparam logic [TIMER_W-1:0] RST_REPEAT     = 16'd100;
    localparam logic [LEVEL_W-1:0] RST_ACTIVE_LOW = 4'd3;

    typedef struct packed {
        logic               func;
        logic [LEVEL_W-1:0] key_levels;
        logic [INDEX_W-1:0] key_index;
        logic [FLAG_W-1:0]  flag_mask;
    } t_in_item;

    typedef struct packed {
        logic              check_hit;
        logic [FLAG_W-1:0] key_flags;
    } t_out_item;

endpackage

[design/key_click_event_detector.sv]
// Key click event detector: per-key debounce sampling, click machines
// and event flags. Depends on kced_pkg.
//
// Usage: each input item is either a tick (func 0) carrying the raw key
// levels, or a check (func 1) that tests and clears the flags of one key.
// Every item yields exactly one result item: a hit bit and the flags of
// the key named by key_index after the item.
// Channels: input i_in_valid / o_in_stall / i_in_item, output
// o_out_valid / i_out_stall / o_out_item, and a configuration write
// channel i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data that is
// always ready. Write configuration only while the block is idle.
// Path: an accepted item lands in the input register, and its result is
// loaded into the output register when the item advances, which waits
// while the output register is full and the receiver stalls.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single pass of per-key logic between the input and output registers.
// Reset: synchronous, active low; clears all key state, the tick counter
// and both valid bits, and restores the register defaults.
// Stall: while the receiver stalls, the result holds; one more item may
// wait in the input register, after which o_in_stall is raised.
module key_click_event_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  kced_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output kced_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kced_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kced_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [kced_pkg::DIV_W-1:0]   r_scan_div;
    logic [kced_pkg::TIMER_W-1:0] r_long_ticks;
    logic [kced_pkg::TIMER_W-1:0] r_double_win;
    logic [kced_pkg::TIMER_W-1:0] r_repeat;
    logic [kced_pkg::LEVEL_W-1:0] r_active_low;

    // Pipeline registers.
    logic                 r_in_valid;
    kced_pkg::t_in_item   r_in;
    logic                 r_out_valid;
    kced_pkg::t_out_item  r_out;

    // Key state.
    logic [kced_pkg::DIV_W-1:0]   r_tick_count;
    logic [kced_pkg::NUM_KEYS-1:0] r_pressed_now;
    logic [kced_pkg::NUM_KEYS-1:0] r_pressed_before;
    logic [kced_pkg::CLICK_W-1:0] r_click [kced_pkg::NUM_KEYS];
    logic [kced_pkg::TIMER_W-1:0] r_timer [kced_pkg::NUM_KEYS];
    logic [kced_pkg::FLAG_W-1:0]  r_flags [kced_pkg::NUM_KEYS];

    logic [kced_pkg::DIV_W-1:0]   n_tick_count;
    logic [kced_pkg::NUM_KEYS-1:0] n_pressed_now;
    logic [kced_pkg::NUM_KEYS-1:0] n_pressed_before;
    logic [kced_pkg::CLICK_W-1:0] n_click [kced_pkg::NUM_KEYS];
    logic [kced_pkg::TIMER_W-1:0] n_timer [kced_pkg::NUM_KEYS];
    logic [kced_pkg::FLAG_W-1:0]  n_flags [kced_pkg::NUM_KEYS];
    kced_pkg::t_out_item          n_out;

    logic advance;
    logic in_accept;
    logic is_tick;
    logic do_sample;
    logic idx_ok;
    logic [kced_pkg::DIV_W-1:0]    tick_inc;
    logic [kced_pkg::NUM_KEYS-1:0] key_active;

    // Handshake: the input register moves on when the output register is
    // free or being emptied in this cycle.
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // Tick counter and sampling decision.
    assign is_tick   = (r_in.func == kced_pkg::FUNC_TICK);
    assign tick_inc  = r_tick_count + kced_pkg::DIV_W'(1);
    assign do_sample = is_tick && (tick_inc >= r_scan_div);
    assign idx_ok    = (32'(r_in.key_index) < kced_pkg::NUM_KEYS);

    // Pressed level of each key after polarity correction.
    assign key_active = r_in.key_levels ^ r_active_low;

    // Per-key timer, edge flags and click machine for the item in the
    // input register.
    always_comb begin
        logic cur;
        logic [kced_pkg::TIMER_W-1:0] t;
        logic [kced_pkg::FLAG_W-1:0] f;

        n_tick_count     = r_tick_count;
        n_pressed_now    = r_pressed_now;
        n_pressed_before = r_pressed_before;
        n_out            = '0;
        if (is_tick) begin
            n_tick_count = do_sample ? '0 : tick_inc;
        end

        for (int k = 0; k < kced_pkg::NUM_KEYS; k++) begin
            cur = key_active[k];
            t   = r_timer[k];
            f   = r_flags[k];
            n_click[k] = r_click[k];

            if (is_tick) begin
                if (t != '0) begin
                    t = t - kced_pkg::TIMER_W'(1);
                end
                if (do_sample) begin
                    n_pressed_before[k] = r_pressed_now[k];
                    n_pressed_now[k]    = cur;
                    if (cur) begin
                        f = f | kced_pkg::FLG_HOLD;
                    end else begin
                        f = f & ~kced_pkg::FLG_HOLD;
                    end
                    if (cur && !r_pressed_now[k]) begin
                        f = f | kced_pkg::FLG_DOWN;
                    end
                    if (!cur && r_pressed_now[k]) begin
                        f = f | kced_pkg::FLG_UP;
                    end

                    unique case (r_click[k])
                        kced_pkg::ST_IDLE: begin
                            if (cur) begin
                                t = r_long_ticks;
                                n_click[k] = kced_pkg::ST_PRESSED;
                            end
                        end
                        kced_pkg::ST_PRESSED: begin
                            if (!cur) begin
                                t = r_double_win;
                                n_click[k] = kced_pkg::ST_WAIT;
                            end else if (t == '0) begin
                                t = r_repeat;
                                f = f | kced_pkg::FLG_LONG;
                                n_click[k] = kced_pkg::ST_REPEAT;
                            end
                        end
                        kced_pkg::ST_WAIT: begin
                            if (cur) begin
                                f = f | kced_pkg::FLG_DOUBLE;
                                n_click[k] = kced_pkg::ST_SECOND;
                            end else if (t == '0) begin
                                f = f | kced_pkg::FLG_SINGLE;
                                n_click[k] = kced_pkg::ST_IDLE;
                            end
                        end
                        kced_pkg::ST_SECOND: begin
                            if (!cur) begin
                                n_click[k] = kced_pkg::ST_IDLE;
                            end
                        end
                        kced_pkg::ST_REPEAT: begin
                            if (!cur) begin
                                n_click[k] = kced_pkg::ST_IDLE;
                            end else if (t == '0) begin
                                t = r_repeat;
                                f = f | kced_pkg::FLG_REPEAT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (idx_ok && (32'(r_in.key_index) == k)) begin
                // Check item: report a hit and clear the tested flags,
                // except when only hold is tested.
                if ((f & r_in.flag_mask) != '0) begin
                    n_out.check_hit = 1'b1;
                    if (r_in.flag_mask != kced_pkg::FLG_HOLD) begin
                        f = f & ~r_in.flag_mask;
                    end
                end
            end

            n_timer[k] = t;
            n_flags[k] = f;
        end

        n_out.key_flags = idx_ok ? n_flags[r_in.key_index] : '0;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_div   <= kced_pkg::RST_SCAN_DIV;
            r_long_ticks <= kced_pkg::RST_LONG_TICKS;
            r_double_win <= kced_pkg::RST_DOUBLE_WIN;
            r_repeat     <= kced_pkg::RST_REPEAT;
            r_active_low <= kced_pkg::RST_ACTIVE_LOW;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kced_pkg::CFG_SCAN_DIV:   r_scan_div   <= i_cfg_data[kced_pkg::DIV_W-1:0];
                kced_pkg::CFG_LONG_TICKS: r_long_ticks <= i_cfg_data;
                kced_pkg::CFG_DOUBLE_WIN: r_double_win <= i_cfg_data;
                kced_pkg::CFG_REPEAT:     r_repeat     <= i_cfg_data;
                kced_pkg::CFG_ACTIVE_LOW: r_active_low <= i_cfg_data[kced_pkg::LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register and its valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
    end

    // Output register: loaded when an item passes, freed when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Key state updates once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count     <= '0;
            r_pressed_now    <= '0;
            r_pressed_before <= '0;
            for (int k = 0; k < kced_pkg::NUM_KEYS; k++) begin
                r_click[k] <= kced_pkg::ST_IDLE;
                r_timer[k] <= '0;
                r_flags[k] <= '0;
            end
        end else if (advance) begin
            r_tick_count     <= n_tick_count;
            r_pressed_now    <= n_pressed_now;
            r_pressed_before <= n_pressed_before;
            for (int k = 0; k < kced_pkg::NUM_KEYS; k++) begin
                r_click[k] <= n_click[k];
                r_timer[k] <= n_timer[k];
                r_flags[k] <= n_flags[k];
            end
        end
    end

`ifndef SYNTH
    // An accepted item is held in the input register at the next edge.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_in_valid)
        else $error("accepted item not captured in input register");

    // A result appears only after an item left the input register.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result without a source item");

    // The click machine agrees with the sampled key level.
    for (genvar g = 0; g < kced_pkg::NUM_KEYS; g++) begin : g_chk
        a_click_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_click[g] == kced_pkg::ST_PRESSED || r_click[g] == kced_pkg::ST_SECOND ||
             r_click[g] == kced_pkg::ST_REPEAT) |-> r_pressed_now[g])
            else $error("click machine holds a press on a released key");

        a_click_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_click[g] == kced_pkg::ST_WAIT) |-> !r_pressed_now[g])
            else $error("click machine waits while key is pressed");
    end
`endif

endmodule

[tb/tb_key_click_event_detector.sv]
// Self-checking testbench for key_click_event_detector: a directed table, then
// random key press sequences checked against a cycle-free event predictor.
// Depends on kced_pkg and the key_click_event_detector RTL.
`timescale 1ns / 1ps

module tb_key_click_event_detector;
    import kced_pkg::*;

    localparam int DIR_ROWS = 24;
    localparam int DIR_CFG_ROW = 6;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 155;
    localparam int STALL_LIMIT = 2000;
    localparam int END_HOLDOFF = 8;

    // Order in which a full register set is written.
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [5] = '{
        CFG_SCAN_DIV, CFG_LONG_TICKS, CFG_DOUBLE_WIN, CFG_REPEAT, CFG_ACTIVE_LOW
    };

    typedef struct packed {
        bit        typed;
        t_out_item exp;
        t_in_item  item;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out_item o_out_item;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    key_click_event_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor copy of the registers.
    logic [DIV_W-1:0]   sample_div   = RST_SCAN_DIV;
    logic [TIMER_W-1:0] long_limit   = RST_LONG_TICKS;
    logic [TIMER_W-1:0] double_limit = RST_DOUBLE_WIN;
    logic [TIMER_W-1:0] repeat_gap   = RST_REPEAT;
    logic [LEVEL_W-1:0] low_active   = RST_ACTIVE_LOW;

    // Predictor copy of the key state.
    logic [DIV_W-1:0]   tick_phase = '0;
    logic [NUM_KEYS-1:0] now_down  = '0;
    logic [NUM_KEYS-1:0] was_down  = '0;
    logic [CLICK_W-1:0] click_st  [NUM_KEYS] = '{default: ST_IDLE};
    logic [TIMER_W-1:0] countdown [NUM_KEYS] = '{default: '0};
    logic [FLAG_W-1:0]  evt_flags [NUM_KEYS] = '{default: '0};

    t_out_item due_key_reports [$];
    int errors = 0;
    int send_idle_pct = 29;
    int recv_idle_pct = 54;
    int quiet_cycles = 0;
    t_dir_row dir_table [DIR_ROWS];

    // Press sequence generator: target state per key and ticks left in it.
    logic [NUM_KEYS-1:0] press_goal = '0;
    int run_left [NUM_KEYS] = '{default: 0};

    // Works out the result of one item and advances the predicted state.
    function automatic t_out_item predict_key_events(t_in_item it);
        t_out_item r;
        logic cur;
        r = '0;
        if (it.func == FUNC_TICK) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (countdown[k] != 0) countdown[k] = countdown[k] - 1'b1;
            end
            tick_phase = tick_phase + 1'b1;
            if (tick_phase >= sample_div) begin
                tick_phase = '0;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    was_down[k] = now_down[k];
                    cur = it.key_levels[k] ^ low_active[k];
                    now_down[k] = cur;
                    if (cur) evt_flags[k] = evt_flags[k] | FLG_HOLD;
                    else evt_flags[k] = evt_flags[k] & ~FLG_HOLD;
                    if (cur && !was_down[k]) evt_flags[k] = evt_flags[k] | FLG_DOWN;
                    if (!cur && was_down[k]) evt_flags[k] = evt_flags[k] | FLG_UP;
                    case (click_st[k])
                        ST_IDLE: begin
                            if (cur) begin
                                countdown[k] = long_limit;
                                click_st[k] = ST_PRESSED;
                            end
                        end
                        ST_PRESSED: begin
                            if (!cur) begin
                                countdown[k] = double_limit;
                                click_st[k] = ST_WAIT;
                            end else if (countdown[k] == 0) begin
                                countdown[k] = repeat_gap;
                                evt_flags[k] = evt_flags[k] | FLG_LONG;
                                click_st[k] = ST_REPEAT;
                            end
                        end
                        ST_WAIT: begin
                            if (cur) begin
                                evt_flags[k] = evt_flags[k] | FLG_DOUBLE;
                                click_st[k] = ST_SECOND;
                            end else if (countdown[k] == 0) begin
                                evt_flags[k] = evt_flags[k] | FLG_SINGLE;
                                click_st[k] = ST_IDLE;
                            end
                        end
                        ST_SECOND: begin
                            if (!cur) click_st[k] = ST_IDLE;
                        end
                        ST_REPEAT: begin
                            if (!cur) begin
                                click_st[k] = ST_IDLE;
                            end else if (countdown[k] == 0) begin
                                countdown[k] = repeat_gap;
                                evt_flags[k] = evt_flags[k] | FLG_REPEAT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end else if ((evt_flags[it.key_index] & it.flag_mask) != 0) begin
            r.check_hit = 1'b1;
            if (it.flag_mask != FLG_HOLD)
                evt_flags[it.key_index] = evt_flags[it.key_index] & ~it.flag_mask;
        end
        r.key_flags = evt_flags[it.key_index];
        return r;
    endfunction

    function automatic t_dir_row dir_row(logic f, logic [LEVEL_W-1:0] lv,
                                         logic [INDEX_W-1:0] ix, logic [FLAG_W-1:0] mk,
                                         bit typed, logic hit, logic [FLAG_W-1:0] flg);
        t_dir_row row;
        row.typed = typed;
        row.exp.check_hit = hit;
        row.exp.key_flags = flg;
        row.item.func = f;
        row.item.key_levels = lv;
        row.item.key_index = ix;
        row.item.flag_mask = mk;
        return row;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // Offers one item after a random gap and records its expected result
    // at the edge where it is accepted.
    task automatic send_item(t_in_item it, bit typed, t_out_item typed_exp);
        t_out_item predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = predict_key_events(it);
        due_key_reports.push_back(typed ? typed_exp : predicted);
    endtask

    // Holds the sender until every pending result has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (due_key_reports.size() != 0) @(posedge i_clk);
    endtask

    // Writes the full register set in REG_ORDER and mirrors it in the predictor.
    task automatic write_regs(logic [CFG_DATA_W-1:0] vals [5]);
        for (int r = 0; r < 5; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_ORDER[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (REG_ORDER[r])
                CFG_SCAN_DIV:   sample_div = vals[r][DIV_W-1:0];
                CFG_LONG_TICKS: long_limit = vals[r];
                CFG_DOUBLE_WIN: double_limit = vals[r];
                CFG_REPEAT:     repeat_gap = vals[r];
                CFG_ACTIVE_LOW: low_active = vals[r][LEVEL_W-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Builds a random item: mostly ticks that follow the press plan of each
    // key, some ticks with random levels, and checks with mixed masks.
    function automatic t_in_item random_item();
        t_in_item it;
        int span;
        it.func = FUNC_TICK;
        it.key_levels = LEVEL_W'($urandom_range(15));
        it.key_index = INDEX_W'($urandom_range(3));
        it.flag_mask = FLAG_W'($urandom_range(127));
        if ($urandom_range(99) < 30) begin
            it.func = FUNC_CHECK;
            case ($urandom_range(5))
                0: it.flag_mask = '0;
                1: it.flag_mask = FLG_HOLD;
                2: it.flag_mask = '1;
                3, 4: it.flag_mask = FLAG_W'(1 << $urandom_range(FLAG_W - 1));
                default: ;
            endcase
        end else begin
            span = (sample_div == 0) ? 1 : int'(sample_div);
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (run_left[k] == 0) begin
                    press_goal[k] = ~press_goal[k];
                    run_left[k] = span * (($urandom_range(3) == 0) ?
                                          $urandom_range(1, 14) : $urandom_range(1, 3));
                end
                run_left[k]--;
                it.key_levels[k] = press_goal[k] ^ low_active[k];
            end
            if ($urandom_range(99) < 12) it.key_levels = LEVEL_W'($urandom_range(15));
        end
        return it;
    endfunction

    // Receiver stall at the rate of the current idling mode.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_key_reports.size() == 0) begin
                report_mismatch("result with nothing pending", o_out_item, 0);
            end else begin
                want = due_key_reports.pop_front();
                if (o_out_item.check_hit !== want.check_hit)
                    report_mismatch("check_hit", o_out_item.check_hit, want.check_hit);
                if (o_out_item.key_flags !== want.key_flags)
                    report_mismatch("key_flags", o_out_item.key_flags, want.key_flags);
            end
        end
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] plan [5];
        logic [CFG_DATA_W-1:0] dir_plan [5];
        t_in_item it;

        // Rows before the directed register write run on the reset values,
        // where no key is sampled yet, so every flag must read clear.
        dir_table[0]  = dir_row(FUNC_CHECK, 4'h0, 2'd0, 7'h7F, 1'b1, 1'b0, 7'h00);
        dir_table[1]  = dir_row(FUNC_CHECK, 4'hF, 2'd3, 7'h00, 1'b1, 1'b0, 7'h00);
        dir_table[2]  = dir_row(FUNC_TICK,  4'hF, 2'd1, 7'h00, 1'b1, 1'b0, 7'h00);
        dir_table[3]  = dir_row(FUNC_TICK,  4'h0, 2'd2, 7'h7F, 1'b1, 1'b0, 7'h00);
        dir_table[4]  = dir_row(FUNC_CHECK, 4'h0, 2'd2, FLG_HOLD, 1'b1, 1'b0, 7'h00);
        dir_table[5]  = dir_row(FUNC_CHECK, 4'h5, 2'd1, 7'h7F, 1'b1, 1'b0, 7'h00);
        // Divider zero and zero times: press, long and repeat on keys 0 and 1.
        dir_table[6]  = dir_row(FUNC_TICK,  4'h0, 2'd0, 7'h00, 1'b0, 1'b0, 7'h00);
        dir_table[7]  = dir_row(FUNC_TICK,  4'h0, 2'd0, 7'h00, 1'b0, 1'b0, 7'h00);
        dir_table[8]  = dir_row(FUNC_TICK,  4'h0, 2'd1, 7'h00, 1'b0, 1'b0, 7'h00);
        // Hold alone, mask zero, then a full clear.
        dir_table[9]  = dir_row(FUNC_CHECK, 4'h0, 2'd0, FLG_HOLD, 1'b0, 1'b0, 7'h00);
        dir_table[10] = dir_row(FUNC_CHECK, 4'h0, 2'd0, 7'h00, 1'b0, 1'b0, 7'h00);
        dir_table[11] = dir_row(FUNC_CHECK, 4'h0, 2'd0, 7'h7F, 1'b0, 1'b0, 7'h00);
        // Release keys 0 and 1, single click then double click on keys 2 and 3.
        dir_table[12] = dir_row(FUNC_TICK,  4'hF, 2'd0, 7'h00, 1'b0, 1'b0, 7'h00);
        dir_table[13] = dir_row(FUNC_TICK,  4'h3, 2'd2, 7'h00, 1'b0, 1'b0, 7'h00);
        dir_table[14] = dir_row(FUNC_TICK,  4'h3, 2'd2, 7'h00, 1'b0, 1'b0, 7'h00);
        dir_table[15] = dir_row(FUNC_TICK,  4'hC, 2'd3, 7'h00, 1'b0, 1'b0, 7'h00);
        dir_table[16] = dir_row(FUNC_TICK,  4'h3, 2'd3, 7'h00, 1'b0, 1'b0, 7'h00);
        dir_table[17] = dir_row(FUNC_TICK,  4'hC, 2'd3, 7'h00, 1'b0, 1'b0, 7'h00);
        dir_table[18] = dir_row(FUNC_TICK,  4'h3, 2'd3, 7'h00, 1'b0, 1'b0, 7'h00);
        dir_table[19] = dir_row(FUNC_CHECK, 4'h0, 2'd2, FLG_SINGLE, 1'b0, 1'b0, 7'h00);
        dir_table[20] = dir_row(FUNC_CHECK, 4'h0, 2'd3, FLG_DOUBLE | FLG_UP,
                                1'b0, 1'b0, 7'h00);
        dir_table[21] = dir_row(FUNC_CHECK, 4'hF, 2'd1, FLG_LONG | FLG_REPEAT,
                                1'b0, 1'b0, 7'h00);
        dir_table[22] = dir_row(FUNC_CHECK, 4'h0, 2'd3, 7'h7F, 1'b0, 1'b0, 7'h00);
        dir_table[23] = dir_row(FUNC_TICK,  4'h0, 2'd2, 7'h7F, 1'b0, 1'b0, 7'h00);
        dir_plan = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0003};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with one register write partway through.
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == DIR_CFG_ROW) begin
                drain_results();
                write_regs(dir_plan);
            end
            send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].exp);
        end

        // Random phases; the idling mode changes every two phases.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p / 2)
                0: begin send_idle_pct = 29; recv_idle_pct = 54; end
                1: begin send_idle_pct = 54; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (p)
                0: plan = '{16'd1, 16'd6, 16'd4, 16'd3, 16'($urandom_range(15))};
                1: plan = '{16'd0, 16'd0, 16'd0, 16'd0, 16'hF};
                2: plan = '{16'd2, 16'd10, 16'd6, 16'd2, 16'h0};
                3: plan = '{16'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'($urandom_range(15))};
                4: plan = '{{8'($urandom), 8'($urandom_range(1, 3))},
                            16'($urandom_range(12)), 16'($urandom_range(8)),
                            16'($urandom_range(5)),
                            {12'($urandom), 4'($urandom_range(15))}};
                default: plan = '{16'd1, 16'd3, 16'd2, 16'd1, 16'($urandom_range(15))};
            endcase
            write_regs(plan);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it = random_item();
                send_item(it, 1'b0, '0);
            end
        end

        drain_results();
        repeat (END_HOLDOFF) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
